### sv/kvs_pkg.sv
// kvs_pkg: shared constants, types and codes for the keyframe vec3 sampler
// no dependencies; imported by kvs_frac_div, kvs_lerp and the top module

package kvs_pkg;

  localparam int MAX_KEYS      = 64;
  localparam int FRACTION_BITS = 16;
  localparam int KEY_IDX_W     = $clog2(MAX_KEYS);
  localparam int KEY_CNT_W     = 7;
  localparam int SLOT_W        = 6;
  localparam int TIME_W        = 32;
  localparam int VAL_W         = 32;
  localparam int VEC_W         = 3 * VAL_W;
  // fraction runs 0 .. 2^FRACTION_BITS inclusive
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int IN_DATA_W     = 168;
  localparam int OUT_DATA_W    = 96;

  // item kinds carried in s_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic [1:0] comp_t;
  localparam comp_t COMP_X = 2'd0;
  localparam comp_t COMP_Y = 2'd1;
  localparam comp_t COMP_Z = 2'd2;

  typedef struct packed {
    logic  valid;
    comp_t comp;
  } lerp_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_VAL_A,
    S_VAL_B,
    S_DIV_WAIT,
    S_LERP,
    S_LERP_WAIT,
    S_HOLD_RD,
    S_EMIT
  } kvs_state_t;

endpackage

### sv/kvs_ram.sv
// kvs_ram: generic single-write, single-read synchronous ram
// registered read; no dependencies

module kvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/kvs_frac_div.sv
// kvs_frac_div: serial restoring divider for the segment fraction
// one quotient bit a cycle; depends on kvs_pkg

module kvs_frac_div import kvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [FRAC_W-1:0] frac
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W:0]   rem;
  logic [TIME_W:0]   rem_sub;
  logic [TIME_W:0]   rem_next;
  logic [TIME_W-1:0] den_r;
  logic [FRAC_W-1:0] quot;
  logic              den_zero;
  logic              ge;

  always_comb begin
    ge       = rem >= {1'b0, den_r};
    rem_sub  = ge ? rem - {1'b0, den_r} : rem;
    // remainder stays below the divisor, so the top bit drops out
    rem_next = {rem_sub[TIME_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(FRAC_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, num};
      den_r    <= den;
      quot     <= '0;
      den_zero <= (den == '0);
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[FRAC_W-2:0], ge};
    end
  end

  // zero-length segment gives fraction zero
  assign frac = den_zero ? '0 : quot;

endmodule

### sv/kvs_lerp.sv
// kvs_lerp: two-stage blend a + floor((b - a) * f / 2^FRACTION_BITS)
// one component per cycle, tagged; depends on kvs_pkg

module kvs_lerp import kvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  lerp_ctl_t               in_ctl,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  logic [FRAC_W-1:0]       frac,
  output lerp_ctl_t               out_ctl,
  output logic [VAL_W-1:0]        res
);

  localparam int PROD_W = VAL_W + 1 + FRAC_W + 1;

  lerp_ctl_t                mid_ctl;
  logic signed [VAL_W:0]    diff;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic [VAL_W-1:0]         a_r;

  always_comb begin
    diff      = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
    prod_next = diff * $signed({1'b0, frac});
    // arithmetic shift is the floor of the scaled product
    prod_sh   = prod >>> FRACTION_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_ctl <= '0;
      out_ctl <= '0;
    end else begin
      mid_ctl <= in_ctl;
      out_ctl <= mid_ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    a_r  <= a;
    // result lies between a and b, so 32 bits hold it
    res  <= a_r + prod_sh[VAL_W-1:0];
  end

endmodule

### sv/keyframe_vec3_sampler_top.sv
// keyframe_vec3_sampler_top: keyframe table with linear vec3 interpolation
// depends on kvs_pkg, kvs_ram, kvs_frac_div, kvs_lerp

// Holds up to 64 keys (unsigned Q16.16 time, signed Q16.16 x/y/z) in two
// synchronous rams: one for times, one for the packed vector. A write item
// (s_tuser = 0) stores a key and returns nothing. A sample item
// (s_tuser = 1) returns one vector: the first key's value at or before the
// first time, the last key's value at or after the last time, otherwise the
// blend over the first segment holding the time, with a truncated 16-bit
// fraction (held in 17 bits so that exactly 1.0 fits). If no segment holds
// the time (unsorted table) the vector is zero and m_tuser is set. The block
// takes one item at a time; a result waiting in the output register does not
// hold off the next item. A clamped sample checks the first key, then the
// last key, and reads that key's value; a blended sample scans the time ram
// one key a cycle, then reads both segment values, runs the serial divider
// and the two-stage blend; a miss scans every key in use after clamping.
// The next item is taken in the cycle after the result is loaded, later if a
// full output register stalls the load; a write leaves the block idle and
// ready for the next item. keys_in_use must be written through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce it. 0 acts
// as 1, values above 64 act as 64. Entries never written read as garbage.

module keyframe_vec3_sampler_top import kvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, low bit up: key_slot[6], key_time[32], key_x[32], key_y[32],
  // key_z[32], sample_time[32], zero pad[2]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: operation[1]
  input  logic                  s_tuser,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, low bit up: out_x[32], out_y[32], out_z[32]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: no_segment[1]
  output logic                  m_tuser,
  // configuration: keys_in_use
  input  logic                  cfg_we,
  input  logic [KEY_CNT_W-1:0]  cfg_wdata
);

  kvs_state_t state, state_next;

  logic [KEY_CNT_W-1:0] keys_in_use;
  logic [KEY_IDX_W-1:0] last_idx;

  // input fields
  logic [SLOT_W-1:0] in_slot;
  logic [TIME_W-1:0] in_key_time;
  logic [VAL_W-1:0]  in_key_x;
  logic [VAL_W-1:0]  in_key_y;
  logic [VAL_W-1:0]  in_key_z;
  logic [TIME_W-1:0] in_sample_time;
  logic              in_xfer;
  logic              slot_ok;

  // ram ports
  logic                 key_we;
  logic [KEY_IDX_W-1:0] key_waddr;
  logic [KEY_IDX_W-1:0] time_raddr;
  logic [KEY_IDX_W-1:0] val_raddr;
  logic [TIME_W-1:0]    time_rdata;
  logic [VEC_W-1:0]     val_rdata;

  // sample working registers
  logic [TIME_W-1:0]    t_query;
  logic [TIME_W-1:0]    t_prev;
  logic [KEY_IDX_W-1:0] cnt;
  logic [VEC_W-1:0]     va;
  logic [VEC_W-1:0]     vb;
  comp_t                comp;
  logic [VAL_W-1:0]     res_x;
  logic [VAL_W-1:0]     res_y;
  logic [VAL_W-1:0]     res_z;
  logic                 res_noseg;

  // compare results against the word coming out of the time ram
  logic le_first;
  logic ge_last;
  logic in_seg;
  logic at_last;

  // divider and blend unit
  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] frac;
  lerp_ctl_t         lerp_in_ctl;
  lerp_ctl_t         lerp_out_ctl;
  logic [VAL_W-1:0]  lerp_a;
  logic [VAL_W-1:0]  lerp_b;
  logic [VAL_W-1:0]  lerp_res;

  logic out_load;

  assign in_slot        = s_tdata[5:0];
  assign in_key_time    = s_tdata[37:6];
  assign in_key_x       = s_tdata[69:38];
  assign in_key_y       = s_tdata[101:70];
  assign in_key_z       = s_tdata[133:102];
  assign in_sample_time = s_tdata[165:134];

  assign in_xfer   = s_tvalid && s_tready;
  assign slot_ok   = int'(in_slot) < MAX_KEYS;
  assign key_waddr = KEY_IDX_W'(in_slot);

  // key count clamped to 1 .. MAX_KEYS, kept as the last index
  always_comb begin
    if (keys_in_use == '0) begin
      last_idx = '0;
    end else if (keys_in_use > KEY_CNT_W'(MAX_KEYS)) begin
      last_idx = KEY_IDX_W'(MAX_KEYS - 1);
    end else begin
      last_idx = KEY_IDX_W'(keys_in_use - 1'b1);
    end
  end

  assign le_first = t_query <= time_rdata;
  assign ge_last  = t_query >= time_rdata;
  assign in_seg   = (t_query >= t_prev) && (t_query <= time_rdata);
  assign at_last  = cnt == last_idx;

  // writes happen only in idle, so no read of a sample overlaps a write
  kvs_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_KEYS)
  ) u_time_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_key_time),
    .raddr (time_raddr),
    .rdata (time_rdata)
  );

  kvs_ram #(
    .WIDTH (VEC_W),
    .DEPTH (MAX_KEYS)
  ) u_val_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata ({in_key_z, in_key_y, in_key_x}),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // fraction = ((t - t0) << FRACTION_BITS) / (t1 - t0), t1 straight off the ram
  kvs_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (t_query - t_prev),
    .den   (time_rdata - t_prev),
    .done  (div_done),
    .frac  (frac)
  );

  kvs_lerp u_lerp (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (lerp_in_ctl),
    .a       (lerp_a),
    .b       (lerp_b),
    .frac    (frac),
    .out_ctl (lerp_out_ctl),
    .res     (lerp_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && (s_tuser == OP_SAMPLE)) begin
          state_next = S_CHK_FIRST;
        end
      end
      S_CHK_FIRST: begin
        state_next = le_first ? S_HOLD_RD : S_CHK_LAST;
      end
      S_CHK_LAST: begin
        state_next = ge_last ? S_HOLD_RD : S_SCAN;
      end
      S_SCAN: begin
        priority if (in_seg) begin
          state_next = S_VAL_A;
        end else if (at_last) begin
          state_next = S_EMIT;
        end
      end
      S_VAL_A:    state_next = S_VAL_B;
      S_VAL_B:    state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_LERP;
        end
      end
      S_LERP: begin
        if (comp == COMP_Z) begin
          state_next = S_LERP_WAIT;
        end
      end
      S_LERP_WAIT: begin
        if (lerp_out_ctl.valid && (lerp_out_ctl.comp == COMP_Z)) begin
          state_next = S_EMIT;
        end
      end
      S_HOLD_RD:  state_next = S_EMIT;
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready          = 1'b0;
    key_we            = 1'b0;
    time_raddr        = '0;
    val_raddr         = '0;
    div_start         = 1'b0;
    lerp_in_ctl.valid = 1'b0;
    lerp_in_ctl.comp  = comp;
    lerp_a            = va[VAL_W-1:0];
    lerp_b            = vb[VAL_W-1:0];
    out_load          = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        key_we     = in_xfer && (s_tuser == OP_WRITE) && slot_ok;
        time_raddr = '0;
      end
      S_CHK_FIRST: begin
        time_raddr = last_idx;
        val_raddr  = '0;
      end
      S_CHK_LAST: begin
        time_raddr = KEY_IDX_W'(1);
        val_raddr  = last_idx;
      end
      S_SCAN: begin
        // next time word in flight, segment start value on the value ram
        time_raddr = cnt + 1'b1;
        val_raddr  = cnt - 1'b1;
        div_start  = in_seg;
      end
      S_VAL_A: begin
        val_raddr = cnt;
      end
      S_LERP: begin
        lerp_in_ctl.valid = 1'b1;
        unique case (comp)
          COMP_X: begin
            lerp_a = va[VAL_W-1:0];
            lerp_b = vb[VAL_W-1:0];
          end
          COMP_Y: begin
            lerp_a = va[2*VAL_W-1:VAL_W];
            lerp_b = vb[2*VAL_W-1:VAL_W];
          end
          COMP_Z: begin
            lerp_a = va[3*VAL_W-1:2*VAL_W];
            lerp_b = vb[3*VAL_W-1:2*VAL_W];
          end
          default: begin
            lerp_a = va[VAL_W-1:0];
            lerp_b = vb[VAL_W-1:0];
          end
        endcase
      end
      S_EMIT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      keys_in_use <= KEY_CNT_W'(1);
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        keys_in_use <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      t_query <= in_sample_time;
    end
    unique case (state)
      S_CHK_FIRST: t_prev <= time_rdata;
      S_CHK_LAST:  cnt    <= KEY_IDX_W'(1);
      S_SCAN: begin
        if (!in_seg) begin
          t_prev <= time_rdata;
          cnt    <= cnt + 1'b1;
          // ran off the end of an unsorted table
          if (at_last) begin
            res_x     <= '0;
            res_y     <= '0;
            res_z     <= '0;
            res_noseg <= 1'b1;
          end
        end
      end
      S_VAL_A: va <= val_rdata;
      S_VAL_B: begin
        vb   <= val_rdata;
        comp <= COMP_X;
      end
      S_LERP: comp <= comp + 1'b1;
      S_HOLD_RD: begin
        res_x     <= val_rdata[VAL_W-1:0];
        res_y     <= val_rdata[2*VAL_W-1:VAL_W];
        res_z     <= val_rdata[3*VAL_W-1:2*VAL_W];
        res_noseg <= 1'b0;
      end
      default: begin
      end
    endcase
    if (lerp_out_ctl.valid) begin
      res_noseg <= 1'b0;
      unique case (lerp_out_ctl.comp)
        COMP_X:  res_x <= lerp_res;
        COMP_Y:  res_y <= lerp_res;
        COMP_Z:  res_z <= lerp_res;
        default: res_x <= lerp_res;
      endcase
    end
    if (out_load) begin
      m_tdata <= {res_z, res_y, res_x};
      m_tuser <= res_noseg;
    end
  end

  // a miss always comes out as a zero vector
  a_noseg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("no_segment result with nonzero vector");

  // blend fraction never exceeds 1.0
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> frac <= FRAC_W'(1 << FRACTION_BITS))
    else $error("fraction out of range");

  // divider wait is entered only after both segment values are read
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_WAIT |-> $past(state) == S_VAL_B || $past(state) == S_DIV_WAIT)
    else $error("divider wait entered out of order");

  // blend results arrive only while the sequencer collects them
  a_lerp_window: assert property (@(posedge clk) disable iff (rst)
    lerp_out_ctl.valid |-> state == S_LERP || state == S_LERP_WAIT)
    else $error("blend result outside blend window");

endmodule
